// ===== rtl/pvim_pkg.sv =====
// shared types, constants and helper functions of the pcm voice mixer
`default_nettype none

package pvim_pkg;

   localparam int STORE_DEPTH     = 65536;
   localparam int ADDR_W          = $clog2(STORE_DEPTH);
   localparam int PHASE_FRAC_BITS = 16;
   localparam int PHASE_INT_BITS  = 17;
   localparam int PHASE_W         = PHASE_INT_BITS + PHASE_FRAC_BITS;
   localparam int SAMPLE_W        = 16;
   localparam int MIX_W           = 32;
   localparam int STEP_W          = 24;
   localparam int VOL_W           = 16;
   localparam int FCOUNT_W        = 17;
   localparam int MUL_W           = 18;
   localparam int PROD_W          = 2 * MUL_W;
   localparam int VOL_SHIFT       = 14;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = STEP_W;

   // operation codes carried in req_tuser
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_START  = 2'd1;
   localparam logic [1:0] OP_RENDER = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDE_SAMPLES = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_TWO_CH   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_COUNT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOOP_ENABLE  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_STEP   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_VOLUME       = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEREO_OUT   = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEAREST_ONLY = 3'd7;

   typedef struct packed {
      logic                wr_en;
      logic [ADDR_W-1:0]   wr_addr;
      logic [SAMPLE_W-1:0] wr_data;
      logic [ADDR_W-1:0]   rd_addr;
   } store_req_type;

   // raw store word to signed sample; narrow mode uses the low byte times 256
   function automatic logic signed [SAMPLE_W-1:0] expand_sample(
      input logic [SAMPLE_W-1:0] raw,
      input logic                wide
   );
      logic signed [SAMPLE_W-1:0] v;
      begin
         if (wide) begin
            v = raw;
         end else begin
            v = {raw[7:0], 8'h00};
         end
         return v;
      end
   endfunction

   // clamp a wide signed sum to the 32-bit mix range
   function automatic logic signed [MIX_W-1:0] sat_mix(
      input logic signed [PROD_W-1:0] v
   );
      logic signed [MIX_W-1:0] r;
      begin
         if (v[PROD_W-1:MIX_W-1] == {(PROD_W-MIX_W+1){1'b0}} ||
             v[PROD_W-1:MIX_W-1] == {(PROD_W-MIX_W+1){1'b1}}) begin
            r = v[MIX_W-1:0];
         end else if (v[PROD_W-1]) begin
            r = {1'b1, {(MIX_W-1){1'b0}}};
         end else begin
            r = {1'b0, {(MIX_W-1){1'b1}}};
         end
         return r;
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/pvim_sample_store.sv =====
// pcm sample store: one write and one registered read per cycle
`default_nettype none

module pvim_sample_store (
   input  wire logic                             clock,
   input  wire pvim_pkg::store_req_type          store_req,
   output logic        [pvim_pkg::SAMPLE_W-1:0]  rd_data
);

   logic [pvim_pkg::SAMPLE_W-1:0] mem [pvim_pkg::STORE_DEPTH];
   logic [pvim_pkg::SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[store_req.wr_addr] <= store_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[store_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/pvim_mac.sv =====
// shared signed multiplier with registered product
`default_nettype none

module pvim_mac (
   input  wire logic                               clock,
   input  wire logic signed [pvim_pkg::MUL_W-1:0]  mul_a,
   input  wire logic signed [pvim_pkg::MUL_W-1:0]  mul_b,
   output logic        signed [pvim_pkg::PROD_W-1:0] prod
);

   logic signed [pvim_pkg::PROD_W-1:0] prod_ff;
   logic signed [pvim_pkg::PROD_W-1:0] prod_in;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// ===== rtl/pcm_voice_interpolating_mixer.sv =====
// pcm playback voice: sequencer, playhead, config registers and mix accumulators
//
// one sample-playback voice. req_ words carry a load, start or render item,
// selected by req_tuser. a load writes one element into the sample store and a
// start clears the playhead; both give no result. a render
// word brings the left and right mix accumulators of one output frame and gives
// exactly one rsp_ word with the accumulators after this voice is added.
// one shared 18x18 multiplier does the interpolation and the volume scaling
// step by step, and the sample store has one read port, so a render reads,
// interpolates, scales and accumulates in turn; a two-channel source reads
// and interpolates each channel, stereo output scales and accumulates each
// output channel. a render past the end of the sample skips the store reads.
// req_tready is low while a render is at work. a finished result waits in the
// output register; if it has not been taken, the next render holds in its last
// step until the register frees. csr_ writes are taken at any edge with
// csr_we high and must come only while the voice is idle.
// reset (synchronous) clears the playhead and the handshake state and loads
// the register defaults. the sample store is not cleared: read only what was
// loaded.
`default_nettype none

module pcm_voice_interpolating_mixer (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // load_address, load_data, mix_left_in, mix_right_in
   input  wire logic [95:0]                           req_tdata,
   // operation
   input  wire logic [1:0]                            req_tuser,
   input  wire logic                                  req_tlast,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // mix_left, mix_right
   output logic [63:0]                                rsp_tdata,
   // produced
   output logic                                       rsp_tuser,
   output logic                                       rsp_tlast,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   input  wire logic                                  csr_we,
   input  wire logic [pvim_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [pvim_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int FW = pvim_pkg::FCOUNT_W;
   localparam int PW = pvim_pkg::PHASE_W;
   localparam int FB = pvim_pkg::PHASE_FRAC_BITS;
   localparam int SW = pvim_pkg::SAMPLE_W;
   localparam int MW = pvim_pkg::MIX_W;
   localparam int UW = pvim_pkg::MUL_W;
   localparam int RW = pvim_pkg::PROD_W;
   localparam int AW = pvim_pkg::ADDR_W;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_RD_A   = 8'b0000_0010,
      ST_RD_B   = 8'b0000_0100,
      ST_DIFF   = 8'b0000_1000,
      ST_INTERP = 8'b0001_0000,
      ST_GAIN   = 8'b0010_0000,
      ST_ACC    = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic                          wide_ff;
   logic                          two_ch_ff;
   logic [FW-1:0]                 fcount_ff;
   logic                          loop_ff;
   logic [pvim_pkg::STEP_W-1:0]   step_ff;
   logic [pvim_pkg::VOL_W-1:0]    volume_ff;
   logic                          stereo_ff;
   logic                          nearest_ff;

   // render state
   logic [PW-1:0]                 playhead_ff, playhead_in;
   logic [FW-1:0]                 cur_idx_ff, cur_idx_in;
   logic [FW-1:0]                 nxt_idx_ff, nxt_idx_in;
   logic                          src_ch_ff, src_ch_in;
   logic                          out_ch_ff, out_ch_in;
   logic signed [SW-1:0]          a_ff, a_in;
   logic signed [SW:0]            s_ff [2];
   logic signed [SW:0]            s_in;
   logic                          s_we;
   logic signed [MW-1:0]          acc_l_ff, acc_l_in;
   logic signed [MW-1:0]          acc_r_ff, acc_r_in;
   logic                          produced_ff, produced_in;
   logic                          bend_ff, bend_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [63:0]                   rsp_data_ff, rsp_data_in;
   logic                          rsp_user_ff, rsp_user_in;
   logic                          rsp_last_ff, rsp_last_in;

   // datapath signals
   pvim_pkg::store_req_type       store_req;
   logic [SW-1:0]                 rd_raw;
   logic signed [UW-1:0]          mul_a, mul_b;
   logic signed [RW-1:0]          prod;

   logic                          req_accept;
   logic [FW-1:0]                 ph_idx;
   logic [FW:0]                   idx_plus;
   logic [FW:0]                   elem_a, elem_b;
   logic signed [SW-1:0]          b_val;
   logic signed [SW:0]            diff;
   logic                          downmix;
   logic signed [SW:0]            s_sel;
   logic signed [SW+1:0]          s_sum;
   logic signed [RW-1:0]          contrib;
   logic signed [RW-1:0]          acc_sum;
   logic signed [MW-1:0]          acc_sat;
   logic [PW:0]                   ph_sum;
   logic [PW-1:0]                 ph_adv;
   logic [PW-1:0]                 ph_end;
   logic                          slot_free;

   pvim_sample_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .rd_data   (rd_raw)
   );

   pvim_mac u_mac (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign ph_idx   = playhead_ff[PW-1:FB];
   assign idx_plus = {1'b0, ph_idx} + {{FW{1'b0}}, 1'b1};

   // element address of the current and next frame for the channel in work
   assign elem_a = two_ch_ff ? {cur_idx_ff, src_ch_ff} : {1'b0, cur_idx_ff};
   assign elem_b = two_ch_ff ? {nxt_idx_ff, src_ch_ff} : {1'b0, nxt_idx_ff};

   always_comb begin
      store_req.wr_en   = req_accept && (req_tuser == pvim_pkg::OP_LOAD);
      store_req.wr_addr = req_tdata[AW-1:0];
      store_req.wr_data = req_tdata[31:16];
      store_req.rd_addr = (state_ff == ST_RD_B) ? elem_b[AW-1:0] : elem_a[AW-1:0];
   end

   assign b_val   = pvim_pkg::expand_sample(rd_raw, wide_ff);
   assign diff    = nearest_ff ? '0 : ({b_val[SW-1], b_val} - {a_ff[SW-1], a_ff});
   assign downmix = two_ch_ff && !stereo_ff;
   assign s_sel   = (two_ch_ff && out_ch_ff) ? s_ff[1] : s_ff[0];
   assign s_sum   = {s_ff[0][SW], s_ff[0]} + {s_ff[1][SW], s_ff[1]};

   always_comb begin
      if (state_ff == ST_DIFF) begin
         mul_a = UW'(diff);
         mul_b = UW'({1'b0, playhead_ff[FB-1:0]});
      end else begin
         mul_a = downmix ? UW'(s_sum) : UW'(s_sel);
         mul_b = UW'({1'b0, volume_ff});
      end
   end

   // interpolated sample: current plus floor of the scaled difference
   assign s_in = a_ff + (SW+1)'(prod >>> FB);

   // downmix halves the sum of both channels
   assign contrib = downmix ? (prod >>> (pvim_pkg::VOL_SHIFT + 1))
                            : (prod >>> pvim_pkg::VOL_SHIFT);
   assign acc_sum = RW'(out_ch_ff ? acc_r_ff : acc_l_ff) + contrib;
   assign acc_sat = pvim_pkg::sat_mix(acc_sum);

   assign ph_sum = {1'b0, playhead_ff} + (PW+1)'(step_ff);
   assign ph_adv = ph_sum[PW] ? {PW{1'b1}} : ph_sum[PW-1:0];
   assign ph_end = {fcount_ff, {FB{1'b0}}};

   always_comb begin
      state_in     = state_ff;
      playhead_in  = playhead_ff;
      cur_idx_in   = cur_idx_ff;
      nxt_idx_in   = nxt_idx_ff;
      src_ch_in    = src_ch_ff;
      out_ch_in    = out_ch_ff;
      a_in         = a_ff;
      s_we         = 1'b0;
      acc_l_in     = acc_l_ff;
      acc_r_in     = acc_r_ff;
      produced_in  = produced_ff;
      bend_in      = bend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_tuser)
                  pvim_pkg::OP_START: begin
                     playhead_in = '0;
                  end
                  pvim_pkg::OP_RENDER: begin
                     acc_l_in  = req_tdata[63:32];
                     acc_r_in  = req_tdata[95:64];
                     bend_in   = req_tlast;
                     src_ch_in = 1'b0;
                     out_ch_in = 1'b0;
                     cur_idx_in = ph_idx;
                     nxt_idx_in = (idx_plus >= {1'b0, fcount_ff}) ? '0 : idx_plus[FW-1:0];
                     if (ph_idx >= fcount_ff) begin
                        produced_in = 1'b0;
                        if (loop_ff) begin
                           playhead_in = '0;
                        end
                        state_in = ST_DONE;
                     end else begin
                        produced_in = 1'b1;
                        state_in    = ST_RD_A;
                     end
                  end
                  pvim_pkg::OP_LOAD, pvim_pkg::OP_NONE: begin
                  end
               endcase
            end
         end
         ST_RD_A: begin
            state_in = ST_RD_B;
         end
         ST_RD_B: begin
            a_in     = b_val;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            state_in = ST_INTERP;
         end
         ST_INTERP: begin
            s_we = 1'b1;
            if (two_ch_ff && !src_ch_ff) begin
               src_ch_in = 1'b1;
               state_in  = ST_RD_A;
            end else begin
               state_in = ST_GAIN;
            end
         end
         ST_GAIN: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (out_ch_ff) begin
               acc_r_in = acc_sat;
            end else begin
               acc_l_in = acc_sat;
            end
            if (stereo_ff && !out_ch_ff) begin
               out_ch_in = 1'b1;
               state_in  = ST_GAIN;
            end else begin
               playhead_in = (loop_ff && ph_adv >= ph_end) ? '0 : ph_adv;
               state_in    = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {acc_r_ff, acc_l_ff};
               rsp_user_in  = produced_ff;
               rsp_last_in  = bend_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         playhead_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         playhead_ff  <= playhead_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_idx_ff  <= cur_idx_in;
      nxt_idx_ff  <= nxt_idx_in;
      src_ch_ff   <= src_ch_in;
      out_ch_ff   <= out_ch_in;
      a_ff        <= a_in;
      acc_l_ff    <= acc_l_in;
      acc_r_ff    <= acc_r_in;
      produced_ff <= produced_in;
      bend_ff     <= bend_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
      if (s_we) begin
         s_ff[src_ch_ff] <= s_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff    <= 1'b1;
         two_ch_ff  <= 1'b0;
         fcount_ff  <= FW'(1);
         loop_ff    <= 1'b0;
         step_ff    <= pvim_pkg::STEP_W'(1 << FB);
         volume_ff  <= pvim_pkg::VOL_W'(1 << pvim_pkg::VOL_SHIFT);
         stereo_ff  <= 1'b1;
         nearest_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            pvim_pkg::CSR_WIDE_SAMPLES: wide_ff    <= csr_wdata[0];
            pvim_pkg::CSR_SRC_TWO_CH:   two_ch_ff  <= csr_wdata[0];
            pvim_pkg::CSR_FRAME_COUNT:  fcount_ff  <= csr_wdata[FW-1:0];
            pvim_pkg::CSR_LOOP_ENABLE:  loop_ff    <= csr_wdata[0];
            pvim_pkg::CSR_PHASE_STEP:   step_ff    <= csr_wdata[pvim_pkg::STEP_W-1:0];
            pvim_pkg::CSR_VOLUME:       volume_ff  <= csr_wdata[pvim_pkg::VOL_W-1:0];
            pvim_pkg::CSR_STEREO_OUT:   stereo_ff  <= csr_wdata[0];
            pvim_pkg::CSR_NEAREST_ONLY: nearest_ff <= csr_wdata[0];
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire
